[rtl/oht_pkg.sv]
package oht_pkg;

   // table size used when the top level is not overridden
   localparam int SLOTS_DEFAULT = 16;

   // field widths fixed by the interface
   localparam int FUNC_W   = 2;
   localparam int HOST_W   = 16;
   localparam int SLOT_W_IO = 4;
   localparam int STATUS_W = 2;

   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [STATUS_W-1:0] status_type;

   // request functions; the fourth code is unused and answers not-open
   localparam func_type FUNC_OPEN   = 2'd0;
   localparam func_type FUNC_CLOSE  = 2'd1;
   localparam func_type FUNC_LOOKUP = 2'd2;

   // result status codes
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_FULL     = 2'd1;
   localparam status_type STATUS_NOT_OPEN = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_OPEN_END,
      ST_RESP
   } state_type;

endpackage

[rtl/oht_host_mem.sv]
module oht_host_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/open_handle_table.sv]
// Handle table: SLOTS local slots map to 16-bit host handles. Valid bits sit in
// flip-flops; host handles sit in a one-port-read, one-port-write RAM with a
// registered read. After reset the block writes slots 0 and 1 (hosts 0 and 1)
// before req_ready rises. One item is in flight at a time. Open scans the RAM
// one slot per cycle, looking for the highest valid slot with the same host
// handle and the lowest free slot. Close and lookup read one entry; a request
// for a slot that is not open, or the unused function code, reads nothing and
// goes straight to the result. The result sits in an output register, so a new
// request is accepted while a result waits for rsp_ready. Slots at or above
// SLOTS read as not open, and rsp_slot_out carries the low 4 bits of the slot
// number.
module open_handle_table #(
   parameter int SLOTS = oht_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [oht_pkg::FUNC_W-1:0]    req_func,
   input  logic [oht_pkg::HOST_W-1:0]    req_host_handle,
   input  logic [oht_pkg::SLOT_W_IO-1:0] req_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [oht_pkg::STATUS_W-1:0]  rsp_status,
   output logic [oht_pkg::SLOT_W_IO-1:0] rsp_slot_out,
   output logic                          rsp_reopened,
   output logic [oht_pkg::HOST_W-1:0]    rsp_host_handle_out
);

   import oht_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   state_type state_ff, state_in;

   // request latched at accept
   func_type            func_ff,  func_in;
   logic [HOST_W-1:0]   host_ff,  host_in;
   logic [SLOT_W-1:0]   idx_ff,   idx_in;

   logic [SLOTS-1:0]    valid_ff, valid_in;
   logic                init_cnt_ff, init_cnt_in;

   // scan pipeline: issue stage and compare stage
   logic [SLOT_W-1:0]   scan_addr_ff, scan_addr_in;
   logic                iss_done_ff,  iss_done_in;
   logic                cmp_vld_ff,   cmp_vld_in;
   logic [SLOT_W-1:0]   cmp_idx_ff,   cmp_idx_in;
   logic                found_ff,      found_in;
   logic [SLOT_W-1:0]   hit_ff,        hit_in;
   logic                free_found_ff, free_found_in;
   logic [SLOT_W-1:0]   free_ff,       free_in;

   // pending result and output register
   status_type          res_status_ff, res_status_in;
   logic [SLOT_W_IO-1:0] res_slot_ff,  res_slot_in;
   logic                res_reopen_ff, res_reopen_in;
   logic [HOST_W-1:0]   res_host_ff,   res_host_in;
   logic                rsp_valid_ff,  rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [SLOT_W_IO-1:0] rsp_slot_ff,  rsp_slot_in;
   logic                rsp_reopen_ff, rsp_reopen_in;
   logic [HOST_W-1:0]   rsp_host_ff,   rsp_host_in;

   // RAM port signals
   logic                mem_wr_en;
   logic [SLOT_W-1:0]   mem_wr_addr;
   logic [HOST_W-1:0]   mem_wr_data;
   logic                mem_rd_en;
   logic [SLOT_W-1:0]   mem_rd_addr;
   logic [HOST_W-1:0]   mem_rd_data;

   logic                req_fire;
   logic [SLOT_W-1:0]   req_idx;
   logic                req_slot_open;
   logic                req_is_access;
   logic                scan_issue;
   logic                scan_last;
   logic                cmp_match;
   logic                cmp_free;
   logic                out_free;

   oht_host_mem #(
      .DEPTH  (SLOTS),
      .ADDR_W (SLOT_W),
      .DATA_W (HOST_W)
   ) u_host_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // request decode
   assign req_ready     = (state_ff == ST_IDLE);
   assign req_fire      = req_valid && req_ready;
   assign req_idx       = SLOT_W'(req_slot);
   assign req_slot_open = (int'(req_slot) < SLOTS) && valid_ff[req_idx];
   assign req_is_access = (req_func == FUNC_CLOSE) || (req_func == FUNC_LOOKUP);

   // scan compare on the entry read last cycle
   assign scan_issue = (state_ff == ST_SCAN) && !iss_done_ff;
   assign scan_last  = cmp_vld_ff && (cmp_idx_ff == LAST_SLOT);
   assign cmp_match  = valid_ff[cmp_idx_ff] && (mem_rd_data == host_ff);
   assign cmp_free   = !valid_ff[cmp_idx_ff];
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (init_cnt_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_func == FUNC_OPEN) begin
                  state_in = ST_SCAN;
               end else if (req_is_access && req_slot_open) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (scan_last) state_in = ST_OPEN_END;
         end
         ST_READ:     state_in = ST_RESP;
         ST_OPEN_END: state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      func_in       = func_ff;
      host_in       = host_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      init_cnt_in   = init_cnt_ff;
      scan_addr_in  = scan_addr_ff;
      iss_done_in   = iss_done_ff;
      cmp_vld_in    = scan_issue;
      cmp_idx_in    = scan_addr_ff;
      found_in      = found_ff;
      hit_in        = hit_ff;
      free_found_in = free_found_ff;
      free_in       = free_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_reopen_in = res_reopen_ff;
      res_host_in   = res_host_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_reopen_in = rsp_reopen_ff;
      rsp_host_in   = rsp_host_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = free_ff;
      mem_wr_data   = host_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = scan_addr_ff;

      case (state_ff)
         ST_INIT: begin
            // slot n holds host n for the two preset slots
            mem_wr_en   = 1'b1;
            mem_wr_addr = SLOT_W'(init_cnt_ff);
            mem_wr_data = HOST_W'(init_cnt_ff);
            init_cnt_in = 1'b1;
         end
         ST_IDLE: begin
            if (req_fire) begin
               func_in       = req_func;
               host_in       = req_host_handle;
               idx_in        = req_idx;
               scan_addr_in  = '0;
               iss_done_in   = 1'b0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               res_status_in = STATUS_NOT_OPEN;
               res_slot_in   = '0;
               res_reopen_in = 1'b0;
               res_host_in   = '0;
               if (req_is_access && req_slot_open) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = req_idx;
               end
            end
         end
         ST_SCAN: begin
            if (scan_issue) begin
               mem_rd_en    = 1'b1;
               scan_addr_in = scan_addr_ff + 1'b1;
               if (scan_addr_ff == LAST_SLOT) iss_done_in = 1'b1;
            end
            // highest match wins, lowest free slot is kept
            if (cmp_vld_ff) begin
               if (cmp_match) begin
                  found_in = 1'b1;
                  hit_in   = cmp_idx_ff;
               end
               if (cmp_free && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in       = cmp_idx_ff;
               end
            end
         end
         ST_OPEN_END: begin
            res_host_in = '0;
            if (found_ff) begin
               res_status_in = STATUS_OK;
               res_slot_in   = SLOT_W_IO'(hit_ff);
               res_reopen_in = 1'b1;
            end else if (free_found_ff) begin
               mem_wr_en         = 1'b1;
               valid_in[free_ff] = 1'b1;
               res_status_in     = STATUS_OK;
               res_slot_in       = SLOT_W_IO'(free_ff);
               res_reopen_in     = 1'b0;
            end else begin
               res_status_in = STATUS_FULL;
               res_slot_in   = '0;
               res_reopen_in = 1'b0;
            end
         end
         ST_READ: begin
            res_status_in = STATUS_OK;
            res_slot_in   = '0;
            res_reopen_in = 1'b0;
            res_host_in   = mem_rd_data;
            if (func_ff == FUNC_CLOSE) valid_in[idx_ff] = 1'b0;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_reopen_in = res_reopen_ff;
               rsp_host_in   = res_host_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         valid_ff     <= {{(SLOTS-2){1'b0}}, 2'b11};
         init_cnt_ff  <= 1'b0;
         iss_done_ff  <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         init_cnt_ff  <= init_cnt_in;
         iss_done_ff  <= iss_done_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      host_ff       <= host_in;
      idx_ff        <= idx_in;
      scan_addr_ff  <= scan_addr_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      hit_ff        <= hit_in;
      free_found_ff <= free_found_in;
      free_ff       <= free_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_reopen_ff <= res_reopen_in;
      res_host_ff   <= res_host_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_reopen_ff <= rsp_reopen_in;
      rsp_host_ff   <= rsp_host_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_out        = rsp_slot_ff;
   assign rsp_reopened        = rsp_reopen_ff;
   assign rsp_host_handle_out = rsp_host_ff;

   // one item in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted while another is in flight");

   // a fresh allocation marks its slot valid
   a_alloc_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OPEN_END) && !found_ff && free_found_ff
      |=> valid_ff[$past(free_ff)])
      else $error("allocated slot not marked valid");

   // a close frees its slot
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) && (func_ff == FUNC_CLOSE)
      |=> !valid_ff[$past(idx_ff)])
      else $error("closed slot still valid");

   // reopen only with status ok
   a_reopen_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_reopen_ff |-> (rsp_status_ff == STATUS_OK))
      else $error("reopen flagged with error status");

   // error results carry no slot and no host handle
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_OK)
      |-> (rsp_slot_ff == '0) && (rsp_host_ff == '0) && !rsp_reopen_ff)
      else $error("error result with nonzero fields");

endmodule

[verif/open_handle_table_tb.sv]
module open_handle_table_tb;
   import oht_pkg::*;

   localparam int SLOTS        = SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS  = 10;

   // the fourth function code has no operation behind it
   localparam func_type FUNC_UNUSED = 2'd3;

   typedef struct packed {
      status_type           status;
      logic [SLOT_W_IO-1:0] slot_out;
      logic                 reopened;
      logic [HOST_W-1:0]    host_out;
   } handle_reply_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   func_type             req_func;
   logic [HOST_W-1:0]    req_host_handle;
   logic [SLOT_W_IO-1:0] req_slot;
   logic                 rsp_valid;
   logic                 rsp_ready;
   status_type           rsp_status;
   logic [SLOT_W_IO-1:0] rsp_slot_out;
   logic                 rsp_reopened;
   logic [HOST_W-1:0]    rsp_host_handle_out;

   // shadow copy of the handle table
   logic              table_valid [SLOTS];
   logic [HOST_W-1:0] table_host [SLOTS];

   handle_reply_type pending_replies[$];

   int  cycle_count;
   int  mismatches;
   int  replies_checked;
   int  opens_seen;
   int  reopens_seen;
   int  full_seen;
   int  closes_seen;
   int  lookups_seen;
   int  unused_seen;
   bit  no_idle;

   open_handle_table #(.SLOTS(SLOTS)) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_host_handle     (req_host_handle),
      .req_slot            (req_slot),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_slot_out        (rsp_slot_out),
      .rsp_reopened        (rsp_reopened),
      .rsp_host_handle_out (rsp_host_handle_out)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding",
                  cycle_count, pending_replies.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // table reset contents: slots 0 and 1 hold hosts 0 and 1
   task automatic clear_table();
      for (int i = 0; i < SLOTS; i++) begin
         table_valid[i] = 1'b0;
         table_host[i]  = '0;
      end
      table_valid[0] = 1'b1;
      table_valid[1] = 1'b1;
      table_host[1]  = 16'd1;
   endtask

   // work out the reply to one request and update the shadow table
   function automatic handle_reply_type serve_request(func_type fn, logic [HOST_W-1:0] host,
                                                      logic [SLOT_W_IO-1:0] sl);
      handle_reply_type reply;
      int               hit;
      int               free_slot;
      reply = '0;
      reply.status = STATUS_NOT_OPEN;
      case (fn)
         FUNC_OPEN: begin
            hit = -1;
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (table_valid[i] && table_host[i] == host) hit = i;
               if (!table_valid[i] && free_slot < 0) free_slot = i;
            end
            opens_seen++;
            if (hit >= 0) begin
               reply.status   = STATUS_OK;
               reply.slot_out = hit[SLOT_W_IO-1:0];
               reply.reopened = 1'b1;
               reopens_seen++;
            end else if (free_slot >= 0) begin
               table_valid[free_slot] = 1'b1;
               table_host[free_slot]  = host;
               reply.status   = STATUS_OK;
               reply.slot_out = free_slot[SLOT_W_IO-1:0];
            end else begin
               reply.status = STATUS_FULL;
               full_seen++;
            end
         end
         FUNC_CLOSE, FUNC_LOOKUP: begin
            if (fn == FUNC_CLOSE) closes_seen++;
            else lookups_seen++;
            // slot numbers past the table read as not open
            if (int'(sl) < SLOTS && table_valid[sl]) begin
               reply.status   = STATUS_OK;
               reply.host_out = table_host[sl];
               if (fn == FUNC_CLOSE) begin
                  table_valid[sl] = 1'b0;
                  table_host[sl]  = '0;
               end
            end
         end
         default: unused_seen++;
      endcase
      return reply;
   endfunction

   // accept side predicts, result side checks against the oldest prediction
   always @(posedge clock) begin
      handle_reply_type want;
      handle_reply_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_slot_out, rsp_reopened, rsp_host_handle_out};
            if (pending_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected reply: status %0d slot %0d reopened %0b host %h",
                           got.status, got.slot_out, got.reopened, got.host_out);
            end else begin
               want = pending_replies.pop_front();
               replies_checked++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"reply %0d mismatch: status %0d/%0d slot %0d/%0d ",
                               "reopened %0b/%0b host %h/%h (expected/actual)"},
                              replies_checked, want.status, got.status,
                              want.slot_out, got.slot_out, want.reopened,
                              got.reopened, want.host_out, got.host_out);
               end
            end
         end
         if (req_valid && req_ready)
            pending_replies.push_back(serve_request(req_func, req_host_handle, req_slot));
      end
   end

   // result backpressure: mostly short stalls, a few long ones
   initial begin
      int r;
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (no_idle) begin
            rsp_ready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
         end else begin
            r = $urandom_range(0, 99);
            if (rsp_ready) begin
               rsp_ready <= 1'b0;
               hold = (r < 85) ? $urandom_range(0, 2) : $urandom_range(10, 60);
            end else begin
               rsp_ready <= 1'b1;
               hold = $urandom_range(0, 12);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // drive one request from a falling edge and hold it until accepted
   task automatic send_item(func_type fn, logic [HOST_W-1:0] host, logic [SLOT_W_IO-1:0] sl);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= fn;
      req_host_handle <= host;
      req_slot        <= sl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [SLOT_W_IO-1:0] pick_open_slot();
      int open_slots[$];
      for (int i = 0; i < SLOTS; i++)
         if (table_valid[i]) open_slots.push_back(i);
      if (open_slots.size() == 0) return SLOT_W_IO'($urandom_range(0, SLOTS - 1));
      return SLOT_W_IO'(open_slots[$urandom_range(0, open_slots.size() - 1)]);
   endfunction

   // slots 0 and 1 come up open, everything else closed
   task automatic test_reset_contents();
      send_item(FUNC_LOOKUP, HOST_W'($urandom), 4'd0);
      send_item(FUNC_LOOKUP, HOST_W'($urandom), 4'd1);
      send_item(FUNC_LOOKUP, HOST_W'($urandom), 4'd2);
      send_item(FUNC_CLOSE, HOST_W'($urandom), 4'd15);
      send_item(FUNC_UNUSED, 16'hFFFF, 4'd15);
   endtask

   // open of a present host reuses its slot; a new host gets the lowest free one
   task automatic test_open_reuse();
      send_item(FUNC_OPEN, 16'h0000, 4'd15);
      send_item(FUNC_OPEN, 16'hFFFF, 4'd0);
      send_item(FUNC_OPEN, 16'hFFFF, 4'd7);
   endtask

   // fill every slot, overflow, then free one and refill it
   task automatic test_full_table();
      for (int i = 3; i < SLOTS; i++)
         send_item(FUNC_OPEN, 16'hA5A5 ^ i[HOST_W-1:0], SLOT_W_IO'($urandom));
      send_item(FUNC_OPEN, 16'h1234, 4'd0);
      send_item(FUNC_CLOSE, HOST_W'($urandom), 4'd5);
      send_item(FUNC_LOOKUP, HOST_W'($urandom), 4'd5);
      send_item(FUNC_OPEN, 16'h7FFF, 4'd0);
   endtask

   // mostly well-formed traffic on live slots, the fill level swinging over time
   task automatic run_traffic(int count);
      int                r;
      int                open_weight;
      int                weights[4];
      func_type          fn;
      logic [HOST_W-1:0] host;
      logic [SLOT_W_IO-1:0] sl;
      weights = '{20, 45, 30, 60};
      open_weight = weights[0];
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0) open_weight = weights[$urandom_range(0, 3)];
         r    = $urandom_range(0, 99);
         host = HOST_W'($urandom);
         sl   = SLOT_W_IO'($urandom);
         if (r < open_weight) begin
            fn = FUNC_OPEN;
            // reuse a live host now and then to hit the reopen path
            if ($urandom_range(0, 99) < 30) host = table_host[pick_open_slot()];
         end else if (r < 95) begin
            fn = ($urandom_range(0, 1) == 0) ? FUNC_CLOSE : FUNC_LOOKUP;
            if ($urandom_range(0, 99) < 75) sl = pick_open_slot();
         end else begin
            fn = FUNC_UNUSED;
         end
         send_item(fn, host, sl);
      end
   endtask

   task automatic test_random_traffic();
      run_traffic(850);
   endtask

   // no gaps on either side
   task automatic test_back_to_back();
      no_idle = 1'b1;
      run_traffic(175);
      no_idle = 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_OPEN;
      req_host_handle = '0;
      req_slot        = '0;
      no_idle         = 1'b0;
      cycle_count     = 0;
      mismatches      = 0;
      replies_checked = 0;
      opens_seen      = 0;
      reopens_seen    = 0;
      full_seen       = 0;
      closes_seen     = 0;
      lookups_seen    = 0;
      unused_seen     = 0;
      clear_table();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_contents();
      test_open_reuse();
      test_full_table();
      test_random_traffic();
      test_back_to_back();
      req_valid <= 1'b0;

      // drain outstanding replies, then watch for strays
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d opens (%0d reopens, %0d on a full table), %0d closes, %0d lookups",
               opens_seen, reopens_seen, full_seen, closes_seen, lookups_seen);
      $display("plus %0d unused codes; %0d replies checked, %0d mismatches",
               unused_seen, replies_checked, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
